FILE: src/mdu_pkg.sv
// ----------------------------------------------------------------------------
// Multiply/divide unit package
// Shared widths, operation codes and the sequencer-to-datapath control beat.
// ----------------------------------------------------------------------------
package mdu_pkg;

  // Operand and result width, and the width of the bit counter.
  localparam int DATA_W = 16;
  localparam int CNT_W  = $clog2(DATA_W);

  // Operation codes carried on the input channel.
  localparam logic [2:0] OP_SDIV = 3'd0;
  localparam logic [2:0] OP_SMOD = 3'd1;
  localparam logic [2:0] OP_UDIV = 3'd2;
  localparam logic [2:0] OP_UMOD = 3'd3;
  localparam logic [2:0] OP_MUL  = 3'd4;

  // Control strobes from the sequencer to the datapath.
  typedef struct packed {
    logic load;    // capture operands at the input beat
    logic step;    // one quotient or product bit
    logic finish;  // result is taken into the output register
  } mdu_ctrl_t;

endpackage

FILE: src/mdu_seq.sv
// ----------------------------------------------------------------------------
// Multiply/divide sequencer
// Walks one item through load, one bit step per cycle, and the final fix-up.
// ----------------------------------------------------------------------------
module mdu_seq
  import mdu_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_fire,
  input  logic      out_free,
  output logic      busy,
  output mdu_ctrl_t ctrl
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_FIX  = 2'd2;

  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DATA_W - 1);

  logic [1:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  // Next state and bit counter.
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = ST_RUN;
          cnt_nxt   = '0;
        end
      end
      ST_RUN: begin
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_LAST) begin
          state_nxt = ST_FIX;
        end
      end
      ST_FIX: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Strobes for the datapath.
  assign busy        = (state_r != ST_IDLE);
  assign ctrl.load   = in_fire;
  assign ctrl.step   = (state_r == ST_RUN);
  assign ctrl.finish = (state_r == ST_FIX) && out_free;

endmodule

FILE: src/mdu_dp.sv
// ----------------------------------------------------------------------------
// Multiply/divide datapath
// Bit-serial restoring divide and shift-add multiply on shared shift registers.
// ----------------------------------------------------------------------------
module mdu_dp
  import mdu_pkg::*;
(
  input  logic              clk,
  input  mdu_ctrl_t         ctrl,
  input  logic [2:0]        operation,
  input  logic [DATA_W-1:0] operand_a,
  input  logic [DATA_W-1:0] operand_b,
  output logic [DATA_W-1:0] result,
  output logic              divide_by_zero
);

  logic [2:0]        op_r;
  logic              neg_q_r, neg_r_r, dz_r;
  logic [DATA_W-1:0] div_r;   // divisor magnitude or multiplicand
  logic [DATA_W-1:0] quo_r;   // dividend shifting out, quotient shifting in
  logic [DATA_W-1:0] rem_r;   // partial remainder or product accumulator

  logic [DATA_W-1:0] quo_nxt, rem_nxt;
  logic              is_signed, na, nb;
  logic [DATA_W-1:0] mag_a, mag_b;
  logic [DATA_W:0]   trial;
  logic [DATA_W-1:0] addend, sel, sel_neg;
  logic              take_quo, do_neg, is_div;

  // Operand magnitudes for the signed operations at the input beat.
  always_comb begin
    is_signed = (operation == OP_SDIV) || (operation == OP_SMOD);
    na        = is_signed && operand_a[DATA_W-1];
    nb        = is_signed && operand_b[DATA_W-1];
    mag_a     = na ? (~operand_a + DATA_W'(1)) : operand_a;
    mag_b     = nb ? (~operand_b + DATA_W'(1)) : operand_b;
  end

  // One bit per step: trial subtract for divide, shift-add for multiply.
  always_comb begin
    trial  = {rem_r, quo_r[DATA_W-1]} - {1'b0, div_r};
    addend = quo_r[DATA_W-1] ? div_r : '0;
    if (op_r == OP_MUL) begin
      rem_nxt = {rem_r[DATA_W-2:0], 1'b0} + addend;
      quo_nxt = {quo_r[DATA_W-2:0], 1'b0};
    end else if (!trial[DATA_W]) begin
      rem_nxt = trial[DATA_W-1:0];
      quo_nxt = {quo_r[DATA_W-2:0], 1'b1};
    end else begin
      rem_nxt = {rem_r[DATA_W-2:0], quo_r[DATA_W-1]};
      quo_nxt = {quo_r[DATA_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      op_r    <= operation;
      neg_q_r <= na ^ nb;
      neg_r_r <= na;
      dz_r    <= (operation <= OP_UMOD) && (operand_b == '0);
      div_r   <= (operation == OP_MUL) ? operand_b : mag_b;
      quo_r   <= (operation == OP_MUL) ? operand_a : mag_a;
      rem_r   <= '0;
    end else if (ctrl.step) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  // Sign fix-up and result selection.
  always_comb begin
    take_quo = 1'b0;
    do_neg   = 1'b0;
    is_div   = 1'b1;
    unique case (op_r)
      OP_SDIV: begin
        take_quo = 1'b1;
        do_neg   = neg_q_r;
      end
      OP_SMOD: begin
        do_neg = neg_r_r;
      end
      OP_UDIV: begin
        take_quo = 1'b1;
      end
      OP_UMOD: begin
        take_quo = 1'b0;
      end
      OP_MUL: begin
        take_quo = 1'b0;
      end
      default: begin
        is_div = 1'b0;
      end
    endcase
    sel     = take_quo ? quo_r : rem_r;
    sel_neg = do_neg ? (~sel + DATA_W'(1)) : sel;
    result  = (dz_r || !is_div) ? '0 : sel_neg;
  end

  assign divide_by_zero = dz_r;

endmodule

FILE: src/int16_mul_div_unit_top.sv
// ----------------------------------------------------------------------------
// 16-bit integer multiply/divide unit
// Signed and unsigned divide and remainder, and low-half multiply.
// ----------------------------------------------------------------------------
// The unit takes one beat at a time and returns one result beat for it. An
// item occupies the unit from its input beat to its result sitting in the
// output register: in the run state the shared shift registers produce one
// quotient or product bit per step, and then the fix-up state applies the
// sign and, once the output register is free, takes the result into it;
// only then is the next input beat taken, so one item is in flight at a
// time. A finished result waits in the output register while the next
// item is accepted. Division by zero gives a result of zero with
// divide_by_zero set, and unused operation codes give zero.
module int16_mul_div_unit_top
  import mdu_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [2:0]        in_operation,
  input  logic [DATA_W-1:0] in_operand_a,
  input  logic [DATA_W-1:0] in_operand_b,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [DATA_W-1:0] out_result,
  output logic              out_divide_by_zero
);

  mdu_ctrl_t         ctrl;
  logic              busy, in_fire, out_free;
  logic [DATA_W-1:0] dp_result;
  logic              dp_dz;
  logic              out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0] out_result_r;
  logic              out_dz_r;

  // Input handshake: one item in flight at a time.
  assign in_stall = busy;
  assign in_fire  = in_valid && !busy;
  assign out_free = !out_valid_r || !out_stall;

  mdu_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .out_free (out_free),
    .busy     (busy),
    .ctrl     (ctrl)
  );

  mdu_dp u_dp (
    .clk            (clk),
    .ctrl           (ctrl),
    .operation      (in_operation),
    .operand_a      (in_operand_a),
    .operand_b      (in_operand_b),
    .result         (dp_result),
    .divide_by_zero (dp_dz)
  );

  // Output register holds the result beat until it is taken.
  always_comb begin
    if (ctrl.finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.finish) begin
      out_result_r <= dp_result;
      out_dz_r     <= dp_dz;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_result         = out_result_r;
  assign out_divide_by_zero = out_dz_r;

endmodule
